@@ src/b85_pkg.sv @@
// Shared types, constants and helper functions of the base-85 stream encoder.
// Used by the packer, the divide stages, the serialiser and the top level.
package b85_pkg;

    localparam int GROUP_BYTES = 4;
    localparam int GROUP_CHARS = 5;
    localparam int DIV_STAGES  = GROUP_CHARS - 1;
    localparam int DIGIT_W     = 7;
    localparam int CHAR_W      = 7;
    localparam int VALUE_W     = 32;
    localparam int COUNT_W     = 3;

    // Reciprocal of 85, scaled by 2**38 and rounded down
    localparam logic [31:0] RECIP_85    = 32'd3233857728;
    localparam int          RECIP_SHIFT = 38;
    localparam logic [31:0] BASE        = 32'd85;

    typedef logic [DIGIT_W-1:0] t_digit;
    typedef logic [CHAR_W-1:0]  t_char;

    // One closed group on its way through the divide chain
    typedef struct packed {
        logic                          valid;
        logic [VALUE_W-1:0]            q;
        logic [GROUP_CHARS-1:0][DIGIT_W-1:0] dg;
        logic [COUNT_W-1:0]            n;
        logic                          last;
    } t_work;

    typedef struct packed {
        logic [VALUE_W-1:0] q;
        t_digit             r;
    } t_divmod;

    // Divide by 85 through the reciprocal; the estimate is at most one low
    function automatic t_divmod div85(input logic [VALUE_W-1:0] v);
        logic [63:0]        prod;
        logic [VALUE_W-1:0] qe;
        logic [VALUE_W-1:0] rem;
        t_divmod            res;
        prod = {32'd0, v} * {32'd0, RECIP_85};
        qe   = {6'd0, prod[63:RECIP_SHIFT]};
        // qe * 85 as shift and add
        rem  = v - ((qe << 6) + (qe << 4) + (qe << 2) + qe);
        if (rem >= BASE) begin
            res.q = qe + 32'd1;
            res.r = t_digit'(rem - BASE);
        end else begin
            res.q = qe;
            res.r = t_digit'(rem);
        end
        return res;
    endfunction

    // Map one base-85 digit to its alphabet character
    function automatic t_char z85_char(input t_digit d);
        t_char c;
        if (d < 7'd10) begin
            c = 7'h30 + d;
        end else if (d < 7'd36) begin
            c = 7'h61 + (d - 7'd10);
        end else if (d < 7'd62) begin
            c = 7'h41 + (d - 7'd36);
        end else begin
            case (d)
                7'd62:   c = 7'h2E;
                7'd63:   c = 7'h2D;
                7'd64:   c = 7'h3A;
                7'd65:   c = 7'h2B;
                7'd66:   c = 7'h3D;
                7'd67:   c = 7'h5E;
                7'd68:   c = 7'h21;
                7'd69:   c = 7'h2F;
                7'd70:   c = 7'h2A;
                7'd71:   c = 7'h3F;
                7'd72:   c = 7'h26;
                7'd73:   c = 7'h3C;
                7'd74:   c = 7'h3E;
                7'd75:   c = 7'h28;
                7'd76:   c = 7'h29;
                7'd77:   c = 7'h5B;
                7'd78:   c = 7'h5D;
                7'd79:   c = 7'h7B;
                7'd80:   c = 7'h7D;
                7'd81:   c = 7'h40;
                7'd82:   c = 7'h25;
                7'd83:   c = 7'h24;
                7'd84:   c = 7'h23;
                default: c = 7'h30;
            endcase
        end
        return c;
    endfunction

endpackage

@@ src/b85_packer.sv @@
// Input side: gathers bytes big-endian into groups and closes a group when it
// is full or the stream ends. Depends on b85_pkg.
module b85_packer import b85_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [7:0]  i_byte,
    input  logic        i_last,
    output t_work       o_work
);

    logic [23:0]        r_pend;
    logic [1:0]         r_cnt;
    t_work              r_work;
    logic               accept;
    logic               close;
    logic [VALUE_W-1:0] n_value;
    logic [COUNT_W-1:0] n_n;

    assign accept = i_valid && i_en;
    assign close  = i_last || (r_cnt == 2'd3);

    // Left-align the group and pad with zeros
    always_comb begin
        case (r_cnt)
            2'd0: begin
                n_value = {i_byte, 24'd0};
                n_n     = 3'd2;
            end
            2'd1: begin
                n_value = {r_pend[7:0], i_byte, 16'd0};
                n_n     = 3'd3;
            end
            2'd2: begin
                n_value = {r_pend[15:0], i_byte, 8'd0};
                n_n     = 3'd4;
            end
            default: begin
                n_value = {r_pend, i_byte};
                n_n     = 3'd5;
            end
        endcase
    end

    // Hold pending bytes; clear them once the group closes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_cnt  <= '0;
        end else if (accept) begin
            if (close) begin
                r_pend <= '0;
                r_cnt  <= '0;
            end else begin
                r_pend <= {r_pend[15:0], i_byte};
                r_cnt  <= r_cnt + 2'd1;
            end
        end
    end

    // Load the closed group into the first work register
    always_ff @(posedge i_clk) begin
        if (i_en && accept && close) begin
            r_work.q    <= n_value;
            r_work.dg   <= '0;
            r_work.n    <= n_n;
            r_work.last <= i_last;
        end
        if (!i_rst_n) begin
            r_work.valid <= 1'b0;
        end else if (i_en) begin
            r_work.valid <= accept && close;
        end
    end

    assign o_work = r_work;

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_last) |=> (r_cnt == 2'd0))
        else $error("pending count not cleared after final byte");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !close) |=> (r_cnt == $past(r_cnt) + 2'd1))
        else $error("pending count did not advance");

    a_group_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && accept && close) |=> r_work.valid)
        else $error("closed group not handed on");

endmodule

@@ src/b85_div_stage.sv @@
// One step of the divide chain: splits off the next base-85 digit by a
// divide by 85 and passes the quotient on. Depends on b85_pkg.
module b85_div_stage import b85_pkg::*; #(
    parameter int STAGE = 1
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  t_work i_work,
    output t_work o_work
);

    // The first stage yields the least significant digit
    localparam int DIGIT = GROUP_CHARS - STAGE;

    t_divmod                             dm;
    t_work                               r_work;
    logic [GROUP_CHARS-1:0][DIGIT_W-1:0] n_dg;

    assign dm = div85(i_work.q);

    // Insert the digit found here
    always_comb begin
        n_dg        = i_work.dg;
        n_dg[DIGIT] = dm.r;
    end

    // Store quotient and digits; advance the valid flag with the chain
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_work.q    <= dm.q;
            r_work.dg   <= n_dg;
            r_work.n    <= i_work.n;
            r_work.last <= i_work.last;
        end
        if (!i_rst_n) begin
            r_work.valid <= 1'b0;
        end else if (i_en) begin
            r_work.valid <= i_work.valid;
        end
    end

    assign o_work = r_work;

endmodule

@@ src/b85_serialiser.sv @@
// Output side: maps a group's digits to characters and sends them one per
// transfer, most significant first, flagging the stream's final character.
// Depends on b85_pkg.
module b85_serialiser import b85_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_work       i_work,
    output logic        o_free,
    output logic        o_valid,
    input  logic        i_ready,
    output t_char       o_char,
    output logic        o_last
);

    logic [GROUP_CHARS-1:0][CHAR_W-1:0] r_chars;
    logic [COUNT_W-1:0]                 r_n;
    logic                               r_last;
    logic [COUNT_W-1:0]                 r_idx;
    logic                               r_busy;
    logic                               final_idx;
    logic                               load;
    logic [GROUP_CHARS-1:0][CHAR_W-1:0] n_chars;

    assign final_idx = (r_idx == r_n - 3'd1);
    assign o_free    = !r_busy || (i_ready && final_idx);
    assign load      = i_work.valid && o_free;

    // Look up every character of the incoming group
    always_comb begin
        for (int i = 0; i < GROUP_CHARS; i++) begin
            n_chars[i] = z85_char(i_work.dg[i]);
        end
        // The last quotient is the most significant digit
        n_chars[0] = z85_char(t_digit'(i_work.q));
    end

    // Track the character being offered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (r_busy && i_ready) begin
            if (final_idx) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    // Hold the group's characters
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_chars <= n_chars;
            r_n     <= i_work.n;
            r_last  <= i_work.last;
        end
    end

    assign o_valid = r_busy;
    assign o_char  = r_chars[r_idx];
    assign o_last  = r_last && final_idx;

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx < r_n))
        else $error("character index beyond group length");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_ready) |=> (r_idx == $past(r_idx)))
        else $error("character index moved while stalled");

endmodule

@@ src/base85_stream_encoder_unit.sv @@
// Base-85 (Z85) stream encoder: takes one byte per transfer, emits characters
// one per transfer. Top level; depends on b85_pkg, b85_packer, b85_div_stage
// and b85_serialiser.
//
// A byte is accepted in any cycle the divide chain can move. A closed group
// (four bytes, or one to three bytes ending the stream) passes an input
// register and four divide-by-85 stages, one multiplier each, and is then
// loaded into the serialiser, which offers its first character. Characters
// leave at one per cycle while the output port is ready, so the output port
// sets the rate. The whole chain stalls only while its last stage holds a
// group that the output side cannot yet take.
module base85_stream_encoder_unit import b85_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] byte_in
    input  logic       s_axis_tlast,   // last_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [6:0] char_out, [7] zero
    output logic       m_axis_tlast    // last_char
);

    t_work w [DIV_STAGES+1];
    logic  en;
    logic  ser_free;
    t_char ser_char;

    // Move the whole chain unless its last stage is stuck
    assign en            = !w[DIV_STAGES].valid || ser_free;
    assign s_axis_tready = en;

    b85_packer u_packer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_axis_tvalid),
        .i_byte  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .o_work  (w[0])
    );

    for (genvar s = 1; s <= DIV_STAGES; s++) begin : g_div
        b85_div_stage #(
            .STAGE (s)
        ) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_work  (w[s-1]),
            .o_work  (w[s])
        );
    end

    b85_serialiser u_ser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_work  (w[DIV_STAGES]),
        .o_free  (ser_free),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_char  (ser_char),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, ser_char};

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (w[DIV_STAGES].valid && m_axis_tvalid))
        else $error("input stalled without a waiting group");

    a_tlast_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast && m_axis_tready) |-> ser_free)
        else $error("final character sent but output side not freed");

endmodule
